// ----- hw/rtl/ipid_pkg.sv -----
`timescale 1ns / 1ps

package ipid_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 15;
  localparam int WEIGHT_W = 9;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // error, first and second difference widths
  localparam int ERR_W = SAMPLE_WIDTH + 1;
  localparam int D1_W  = SAMPLE_WIDTH + 2;
  localparam int D2_W  = SAMPLE_WIDTH + 3;
  localparam int MB_W  = D2_W;
  localparam int PROD_W = GAIN_W + MB_W;
  localparam int ACC_W  = GAIN_W + SAMPLE_WIDTH + 6;

  // blend weight is unsigned Q1.8, saturated to 1.0 in the datapath
  localparam int BLEND_FRAC = 8;
  localparam int BLEND_W    = PROD_W + 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KP_GAIN       = 3'd0,
    REG_KI_GAIN       = 3'd1,
    REG_KD_GAIN       = 3'd2,
    REG_DRIVE_LIMIT   = 3'd3,
    REG_SMOOTH_ENABLE = 3'd4,
    REG_SMOOTH_WEIGHT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp_gain;
    logic signed [GAIN_W-1:0] ki_gain;
    logic signed [GAIN_W-1:0] kd_gain;
    logic [LIMIT_W-1:0]       drive_limit;
    logic                     smooth_enable;
    logic [WEIGHT_W-1:0]      smooth_weight;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_KP,
    MUL_KI,
    MUL_KD,
    MUL_BLEND
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_add;
    logic     clamp_en;
    logic     commit;
  } dp_cmd_t;

endpackage

// ----- hw/rtl/ipid_regs.sv -----
`timescale 1ns / 1ps

module ipid_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ipid_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ipid_pkg::cfg_t                      cfg
);
  import ipid_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain       <= '0;
      cfg.ki_gain       <= '0;
      cfg.kd_gain       <= '0;
      cfg.drive_limit   <= LIMIT_W'(32767);
      cfg.smooth_enable <= 1'b0;
      cfg.smooth_weight <= WEIGHT_W'(77);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KP_GAIN:       cfg.kp_gain       <= cfg_data[GAIN_W-1:0];
        REG_KI_GAIN:       cfg.ki_gain       <= cfg_data[GAIN_W-1:0];
        REG_KD_GAIN:       cfg.kd_gain       <= cfg_data[GAIN_W-1:0];
        REG_DRIVE_LIMIT:   cfg.drive_limit   <= cfg_data[LIMIT_W-1:0];
        REG_SMOOTH_ENABLE: cfg.smooth_enable <= cfg_data[0];
        REG_SMOOTH_WEIGHT: cfg.smooth_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ipid_ctrl.sv -----
`timescale 1ns / 1ps

module ipid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ipid_pkg::dp_cmd_t cmd
);
  import ipid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_ACC_D,
    S_CLAMP,
    S_BLEND,
    S_FINISH
  } state_t;

  state_t state;
  logic   in_accept;
  logic   out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_KP;
    unique case (state)
      S_IDLE:   cmd.load = in_accept;
      S_MUL_P:  begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KP;
      end
      S_MUL_I:  begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KI;
        cmd.acc_add = 1'b1;
      end
      S_MUL_D:  begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KD;
        cmd.acc_add = 1'b1;
      end
      S_ACC_D:  cmd.acc_add = 1'b1;
      S_CLAMP:  cmd.clamp_en = 1'b1;
      S_BLEND:  begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BLEND;
      end
      S_FINISH: cmd.commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   if (in_accept) state <= S_MUL_P;
        S_MUL_P:  state <= S_MUL_I;
        S_MUL_I:  state <= S_MUL_D;
        S_MUL_D:  state <= S_ACC_D;
        S_ACC_D:  state <= S_CLAMP;
        S_CLAMP:  state <= S_BLEND;
        S_BLEND:  state <= S_FINISH;
        S_FINISH: if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ipid_dp.sv -----
`timescale 1ns / 1ps

module ipid_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  ipid_pkg::cfg_t                           cfg,
  input  ipid_pkg::dp_cmd_t                        cmd,
  input  logic signed [ipid_pkg::SAMPLE_WIDTH-1:0] setpoint,
  input  logic signed [ipid_pkg::SAMPLE_WIDTH-1:0] measured,
  output logic signed [ipid_pkg::SAMPLE_WIDTH-1:0] drive
);
  import ipid_pkg::*;

  localparam logic signed [ACC_W-1:0] MAX_MAG =
    ACC_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    ACC_W'(64'd1 << (GAIN_FRAC_BITS - 1));
  localparam logic signed [BLEND_W-1:0] BLEND_HALF =
    BLEND_W'(64'd1 << (BLEND_FRAC - 1));
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(64'd1 << BLEND_FRAC);

  // state carried between items
  logic signed [ERR_W-1:0]        err_now;
  logic signed [ERR_W-1:0]        err_prev;
  logic signed [SAMPLE_WIDTH-1:0] drive_held;

  // per-item working registers
  logic signed [ERR_W-1:0]        e_cur;
  logic signed [D1_W-1:0]         d1;
  logic signed [D2_W-1:0]         d2;
  logic signed [ACC_W-1:0]        acc;
  logic signed [PROD_W-1:0]       prod;
  logic signed [SAMPLE_WIDTH-1:0] clampv;

  logic signed [ERR_W-1:0]        e_in;
  logic signed [D1_W-1:0]         d1_in;
  logic signed [D2_W-1:0]         d2_in;
  logic signed [GAIN_W-1:0]       mul_a;
  logic signed [MB_W-1:0]         mul_b;
  logic [WEIGHT_W-1:0]            w_sat;
  logic signed [ERR_W-1:0]        blend_diff;
  logic signed [ACC_W-1:0]        shifted;
  logic signed [ACC_W-1:0]        lim;
  logic signed [ACC_W-1:0]        clamp_res;
  logic signed [BLEND_W-1:0]      blend_sum;
  logic signed [BLEND_W-1:0]      blend_shr;
  logic signed [SAMPLE_WIDTH-1:0] result;

  assign e_in  = ERR_W'(setpoint) - ERR_W'(measured);
  assign d1_in = D1_W'(e_in) - D1_W'(err_now);
  assign d2_in = D2_W'(e_in) - (D2_W'(err_now) <<< 1) + D2_W'(err_prev);

  assign w_sat      = (cfg.smooth_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smooth_weight;
  assign blend_diff = ERR_W'(drive_held) - ERR_W'(clampv);

  always_comb begin
    mul_a = cfg.kp_gain;
    mul_b = MB_W'(d1);
    case (cmd.mul_sel)
      MUL_KP: begin
        mul_a = cfg.kp_gain;
        mul_b = MB_W'(d1);
      end
      MUL_KI: begin
        mul_a = cfg.ki_gain;
        mul_b = MB_W'(e_cur);
      end
      MUL_KD: begin
        mul_a = cfg.kd_gain;
        mul_b = MB_W'(d2);
      end
      MUL_BLEND: begin
        mul_a = GAIN_W'(w_sat);
        mul_b = MB_W'(blend_diff);
      end
      default: ;
    endcase
  end

  // round half up was folded into acc at load, so the shift is a floor
  assign shifted = acc >>> GAIN_FRAC_BITS;
  assign lim = (ACC_W'(cfg.drive_limit) > MAX_MAG) ? MAX_MAG : ACC_W'(cfg.drive_limit);

  always_comb begin
    if (shifted <= -lim) begin
      clamp_res = -lim;
    end else if (shifted >= lim) begin
      clamp_res = lim;
    end else begin
      clamp_res = shifted;
    end
  end

  // held*w + v*(1-w) rewritten as v + (held - v)*w
  assign blend_sum = (BLEND_W'(clampv) <<< BLEND_FRAC) + BLEND_W'(prod) + BLEND_HALF;
  assign blend_shr = blend_sum >>> BLEND_FRAC;
  assign result    = cfg.smooth_enable ? blend_shr[SAMPLE_WIDTH-1:0] : clampv;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_cur <= e_in;
      d1    <= d1_in;
      d2    <= d2_in;
      acc   <= (ACC_W'(drive_held) <<< GAIN_FRAC_BITS) + ROUND_HALF;
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.clamp_en) begin
      clampv <= clamp_res[SAMPLE_WIDTH-1:0];
    end
    if (cmd.commit) begin
      drive <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_now    <= '0;
      err_prev   <= '0;
      drive_held <= '0;
    end else if (cmd.commit) begin
      err_prev   <= err_now;
      err_now    <= e_cur;
      drive_held <= result;
    end
  end

endmodule

// ----- hw/rtl/incremental_pid_with_output_smoothing_top.sv -----
`timescale 1ns / 1ps
// after an input transfer: three products on one shared multiplier, a final add, clamp,
// one blend product, then the output register that drives out_valid and drive
// a new input is taken only in idle, once the controller sequence over the shared multiplier ends
// a finished drive waiting under stall holds the controller in its last step
// synchronous active-high reset clears gains to 0, limit to 32767, weight to 77,
// smoothing off, error history and held drive to 0
module incremental_pid_with_output_smoothing_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [ipid_pkg::SAMPLE_WIDTH-1:0] setpoint,
  input  logic signed [ipid_pkg::SAMPLE_WIDTH-1:0] measured,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [ipid_pkg::SAMPLE_WIDTH-1:0] drive,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [ipid_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]          cfg_data
);
  import ipid_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  ipid_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ipid_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .setpoint (setpoint),
    .measured (measured),
    .drive    (drive)
  );

endmodule

// ----- hw/rtl/ipid_checker.sv -----
`timescale 1ns / 1ps

module ipid_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     in_valid,
  input logic                                     in_stall,
  input logic                                     out_valid,
  input logic                                     out_stall,
  input logic signed [ipid_pkg::SAMPLE_WIDTH-1:0] drive
);
  import ipid_pkg::*;

  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive))
    else $error("stalled drive changed");

  // the block is busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without processing");

  // reset leaves no result pending and the input open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // clamp and blend keep the drive inside the symmetric range
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive != MOST_NEG)
    else $error("drive outside symmetric range");

endmodule

bind incremental_pid_with_output_smoothing_top ipid_checker u_chk (.*);
